FILE: rtl/core/interleaved_crc_generate_check_assert.svh
// ----------------------------------------------------------------------------
// interleaved crc assertion macros
// concurrent assertion wrappers used by icrc_emit of the interleaved crc rtl
// ----------------------------------------------------------------------------
`ifndef INTERLEAVED_CRC_GENERATE_CHECK_ASSERT_SVH
`define INTERLEAVED_CRC_GENERATE_CHECK_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define ICRC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// same-cycle implication outside reset
`define ICRC_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/icrc_pkg.sv
// ----------------------------------------------------------------------------
// icrc_pkg
// shared constants, register codes and types of the interleaved crc block
// ----------------------------------------------------------------------------
`default_nettype none

package icrc_pkg;

   localparam int LANES  = 8;
   localparam int POLY_W = 64;
   localparam int SIZE_W = 7;
   localparam int MSG_W  = 16;
   localparam int POS_W  = 17;
   localparam int BIT_W  = 6;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 64;

   localparam logic [1:0] REG_POLY = 2'd0;
   localparam logic [1:0] REG_SIZE = 2'd1;
   localparam logic [1:0] REG_MSG  = 2'd2;
   localparam logic [1:0] REG_MODE = 2'd3;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd32;
   localparam logic [MSG_W-1:0]  MSG_RESET  = 16'd1024;

   typedef struct packed {
      logic [POLY_W-1:0] poly;
      logic [SIZE_W-1:0] size;
      logic [MSG_W-1:0]  msg_bits;
      logic              check_mode;
   } cfg_type;

   typedef struct packed {
      logic                         valid;
      logic                         is_check;
      logic [SIZE_W-1:0]            count;
      logic [LANES-1:0]             flags;
      logic                         all_match;
      logic [LANES-1:0][POLY_W-1:0] rems;
   } load_type;

endpackage

`default_nettype wire

FILE: rtl/core/interleaved_crc_generate_check.sv
// a request that ends a run is captured in the snapshot buffer, then its first response in the response register
// throughput: one request per cycle while the per-lane lfsr registers absorb bits
// a generate run then drains one response per crc bit, one per cycle while rsp_ready is high, from the snapshot buffer
// a request that ends a run waits while the previous run's responses still drain
// reset is synchronous and active high: config registers return to defaults, remainders clear
// ----------------------------------------------------------------------------
// interleaved_crc_generate_check
// multi-lane crc generator and checker with configurable polynomial and size
// ----------------------------------------------------------------------------
`default_nettype none

module interleaved_crc_generate_check
   import icrc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [LANES-1:0]  req_lane_bits,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [LANES-1:0]  rsp_out_bits,
   output logic                   rsp_all_match,
   output logic                   rsp_last,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic      [DATA_W-1:0] csr_prdata,
   output logic                   csr_pready
);

   cfg_type  cfg;
   load_type load;
   logic     buf_busy;

   icrc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   icrc_lanes u_lanes (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_lane_bits (req_lane_bits),
      .buf_busy      (buf_busy),
      .load          (load)
   );

   icrc_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .buf_busy      (buf_busy),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_bits  (rsp_out_bits),
      .rsp_all_match (rsp_all_match),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

FILE: rtl/core/icrc_csr.sv
// ----------------------------------------------------------------------------
// icrc_csr
// apb-style configuration registers of the interleaved crc block
// ----------------------------------------------------------------------------
`default_nettype none

module icrc_csr
   import icrc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [ADDR_W-1:0] csr_paddr,
   input  wire logic [DATA_W-1:0] csr_pwdata,
   output logic      [DATA_W-1:0] csr_prdata,
   output logic                   csr_pready,
   output cfg_type                cfg
);

   logic [POLY_W-1:0] poly_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [MSG_W-1:0]  msg_ff;
   logic              mode_ff;
   logic [1:0]        reg_sel;
   logic              wr_en;

   assign reg_sel    = csr_paddr[4:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= '0;
         size_ff <= SIZE_RESET;
         msg_ff  <= MSG_RESET;
         mode_ff <= 1'b0;
      end else if (wr_en) begin
         case (reg_sel)
            REG_POLY: poly_ff <= csr_pwdata;
            REG_SIZE: size_ff <= csr_pwdata[SIZE_W-1:0];
            REG_MSG:  msg_ff  <= csr_pwdata[MSG_W-1:0];
            REG_MODE: mode_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_POLY: csr_prdata = poly_ff;
         REG_SIZE: csr_prdata = {{(DATA_W-SIZE_W){1'b0}}, size_ff};
         REG_MSG:  csr_prdata = {{(DATA_W-MSG_W){1'b0}}, msg_ff};
         REG_MODE: csr_prdata = {{(DATA_W-1){1'b0}}, mode_ff};
         default:  csr_prdata = '0;
      endcase
   end

   assign cfg.poly       = poly_ff;
   assign cfg.size       = size_ff;
   assign cfg.msg_bits   = msg_ff;
   assign cfg.check_mode = mode_ff;

endmodule

`default_nettype wire

FILE: rtl/core/icrc_lanes.sv
// ----------------------------------------------------------------------------
// icrc_lanes
// per-lane crc remainder registers, run position and check mismatch flags
// ----------------------------------------------------------------------------
`default_nettype none

module icrc_lanes
   import icrc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  cfg_type               cfg,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [LANES-1:0] req_lane_bits,
   input  wire logic             buf_busy,
   output load_type              load
);

   logic [LANES-1:0][POLY_W-1:0] rem_ff, rem_in, rem_abs;
   logic [POS_W-1:0]             pos_ff, pos_in, pos_inc;
   logic [LANES-1:0]             mism_ff, mism_in, mism_next;

   logic [SIZE_W-1:0] size_eff, size_dec;
   logic [BIT_W-1:0]  size_m1, crc_bit;
   logic [POLY_W-1:0] mask, poly_m;
   logic [POS_W-1:0]  msg_eff, k;
   logic [POS_W:0]    k_inc;
   logic              in_crc, k_lt_n, check_end, gen_end, ends_run, accept, do_absorb;
   logic [LANES-1:0]  crc_word;

   always_comb begin
      if (cfg.size == '0) begin
         size_eff = 7'd1;
      end else if (cfg.size > 7'd64) begin
         size_eff = 7'd64;
      end else begin
         size_eff = cfg.size;
      end
   end

   assign size_dec = size_eff - 7'd1;
   assign size_m1  = size_dec[BIT_W-1:0];
   assign mask     = {POLY_W{1'b1}} >> (7'd64 - size_eff);
   assign poly_m   = cfg.poly & mask;
   assign msg_eff  = {1'b0, (cfg.msg_bits == '0) ? 16'd1 : cfg.msg_bits};

   assign pos_inc   = pos_ff + 17'd1;
   assign in_crc    = pos_ff >= msg_eff;
   assign k         = pos_ff - msg_eff;
   assign k_inc     = {1'b0, k} + 18'd1;
   assign k_lt_n    = k < {10'd0, size_eff};
   assign crc_bit   = k_lt_n ? (size_m1 - k[BIT_W-1:0]) : '0;
   assign check_end = in_crc && (k_inc >= {11'd0, size_eff});
   assign gen_end   = pos_inc >= msg_eff;
   assign ends_run  = cfg.check_mode ? check_end : gen_end;
   assign do_absorb = !cfg.check_mode || !in_crc;

   assign req_ready = !(buf_busy && ends_run);
   assign accept    = req_valid && req_ready;

   // one lfsr step per lane
   always_comb begin
      logic [POLY_W-1:0] r;
      logic              fb;
      for (int l = 0; l < LANES; l++) begin
         r           = rem_ff[l] & mask;
         fb          = r[size_m1] ^ req_lane_bits[l];
         rem_abs[l]  = ((r << 1) & mask) ^ (fb ? poly_m : '0);
         crc_word[l] = rem_ff[l][crc_bit];
      end
   end

   assign mism_next = mism_ff | (crc_word ^ req_lane_bits);

   always_comb begin
      rem_in  = rem_ff;
      pos_in  = pos_ff;
      mism_in = mism_ff;
      if (accept) begin
         if (ends_run) begin
            rem_in  = '0;
            pos_in  = '0;
            mism_in = '0;
         end else begin
            pos_in = pos_inc;
            if (do_absorb) begin
               rem_in = rem_abs;
            end else begin
               mism_in = mism_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff  <= '0;
         pos_ff  <= '0;
         mism_ff <= '0;
      end else begin
         rem_ff  <= rem_in;
         pos_ff  <= pos_in;
         mism_ff <= mism_in;
      end
   end

   assign load.valid     = accept && ends_run;
   assign load.is_check  = cfg.check_mode;
   assign load.count     = cfg.check_mode ? 7'd1 : size_eff;
   assign load.flags     = ~mism_next;
   assign load.all_match = (mism_next == '0);
   assign load.rems      = rem_abs;

endmodule

`default_nettype wire

FILE: rtl/core/icrc_emit.sv
// ----------------------------------------------------------------------------
// icrc_emit
// end-of-run snapshot buffer and registered response stage
// ----------------------------------------------------------------------------
`default_nettype none

`include "interleaved_crc_generate_check_assert.svh"

module icrc_emit
   import icrc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  load_type         load,
   output logic             buf_busy,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [LANES-1:0] rsp_out_bits,
   output logic             rsp_all_match,
   output logic             rsp_last
);

   logic [LANES-1:0][POLY_W-1:0] rems_ff;
   logic [BIT_W-1:0]             bit_ff;
   logic [SIZE_W-1:0]            cnt_ff, cnt_dec;
   logic                         check_ff, all_ff;
   logic [LANES-1:0]             flags_ff, word;

   logic                         rsp_valid_ff, rsp_all_ff, rsp_last_ff;
   logic [LANES-1:0]             rsp_bits_ff;
   logic                         take;

   assign buf_busy = cnt_ff != '0;
   assign take     = buf_busy && (!rsp_valid_ff || rsp_ready);
   assign cnt_dec  = load.count - 7'd1;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         word[l] = rems_ff[l][bit_ff];
      end
   end

   // snapshot payload
   always_ff @(posedge clock) begin
      if (load.valid) begin
         rems_ff  <= load.rems;
         bit_ff   <= cnt_dec[BIT_W-1:0];
         check_ff <= load.is_check;
         flags_ff <= load.flags;
         all_ff   <= load.all_match;
      end else if (take) begin
         bit_ff <= bit_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load.valid) begin
         cnt_ff <= load.count;
      end else if (take) begin
         cnt_ff <= cnt_ff - 7'd1;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_bits_ff <= check_ff ? flags_ff : word;
         rsp_all_ff  <= check_ff && all_ff;
         rsp_last_ff <= check_ff || (cnt_ff == 7'd1);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_bits  = rsp_bits_ff;
   assign rsp_all_match = rsp_all_ff;
   assign rsp_last      = rsp_last_ff;

   `ICRC_ASSERT_IMPL(load_into_empty, clock, reset, load.valid, cnt_ff == '0, "load while busy")
   `ICRC_ASSERT(count_bounded, clock, reset, cnt_ff <= 7'd64, "count out of range")
   `ICRC_ASSERT_IMPL(verdict_single, clock, reset, check_ff && buf_busy, cnt_ff == 7'd1, "multi verdict")

endmodule

`default_nettype wire
